FILE: hdl/assert_macros.svh
// Assertion helpers; every check is clocked on clk and off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every edge
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// cons must hold at the next edge after ante
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/tccs_pkg.sv
`default_nettype none
package tccs_pkg;

	localparam int DEF_COLUMNS  = 80;
	localparam int DEF_CELLS    = 2000;
	localparam int DEF_TAB_STOP = 8;

	localparam logic [15:0] BLANK_CELL   = 16'h0720;
	localparam logic [7:0]  CH_NEWLINE   = 8'd10;
	localparam logic [7:0]  CH_TAB       = 8'd9;
	localparam logic [7:0]  CH_BACKSPACE = 8'd8;

	localparam logic OP_PUT  = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef struct packed {
		logic        operation;
		logic [7:0]  char_code;
		logic [10:0] cell_index;
	} tccs_in_t;

	typedef struct packed {
		logic [10:0] cursor_out;
		logic [15:0] cell_value;
		logic        scrolled;
	} tccs_out_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_EXEC   = 4'b0010,
		ST_SCROLL = 4'b0100,
		ST_DONE   = 4'b1000
	} tccs_state_t;

endpackage
`default_nettype wire

FILE: hdl/tccs_chan_if.sv
`default_nettype none
interface tccs_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/tccs_screen.sv
`default_nettype none
module tccs_screen import tccs_pkg::*; #(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int CELLS   = DEF_CELLS,
	localparam int AW     = $clog2(CELLS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [AW-1:0] rd_addr,
	output logic [15:0]   rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [15:0]   wr_data,
	input  logic          scroll_start,
	output logic          busy
);

	localparam int KW     = $clog2(CELLS + 1);
	localparam int COPY_N = (CELLS > COLUMNS) ? CELLS - COLUMNS : 0;

	logic [15:0]   mem [CELLS];
	logic [15:0]   rd_q;

	logic          sweep_q;
	logic          copy_q;
	logic [KW-1:0] k_q;
	logic          pend_s1;
	logic          copy_s1;
	logic [AW-1:0] dst_s1;

	logic          copy_now;
	logic [KW+8:0] src_w;
	logic [AW-1:0] mem_ra;

	// sweep: read cell k+COLUMNS, write it to cell k in the next cycle;
	// cells past the copy range (or all of them on a clear) get a blank
	assign copy_now = copy_q && (32'(k_q) < COPY_N);
	assign src_w    = (KW+9)'(k_q) + (KW+9)'(COLUMNS);
	assign mem_ra   = sweep_q ? src_w[AW-1:0] : rd_addr;
	assign rd_data  = rd_q;
	assign busy     = sweep_q | pend_s1;

	always_ff @(posedge clk) begin
		if (pend_s1) begin
			mem[dst_s1] <= copy_s1 ? rd_q : BLANK_CELL;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q    <= mem[mem_ra];
		copy_s1 <= copy_now;
		dst_s1  <= k_q[AW-1:0];
	end

	// out of reset the sweep runs in blank mode: that is the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= 1'b1;
			copy_q  <= 1'b0;
			k_q     <= '0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= sweep_q;
			if (scroll_start) begin
				sweep_q <= 1'b1;
				copy_q  <= 1'b1;
				k_q     <= '0;
			end else if (sweep_q) begin
				k_q <= k_q + KW'(1);
				if (k_q == KW'(CELLS - 1)) begin
					sweep_q <= 1'b0;
				end
			end
		end
	end

endmodule
`default_nettype wire

FILE: hdl/text_console_cursor_scroll_core.sv
// Channel | Dir | Word                                        | Moves when
// req     | in  | operation, char_code, cell_index            | valid & ready
// rsp     | out | cursor_out, cell_value, scrolled            | valid & ready
//
// A read or an ordinary put is accepted (store read issued), then goes
// through modify/write-back with the result loaded into the output register.
// A put that scrolls then waits in SCROLL: the store sweep moves one cell per
// cycle through the single read and write port and keeps it busy; SCROLL sees
// the sweep end and DONE loads the output.
// After reset a clearing pass blanks the store; req.ready stays low until it
// ends. A stalled rsp holds the finished word while the next item may already
// be accepted; a second result waits until it drains.
`default_nettype none
`include "assert_macros.svh"
module text_console_cursor_scroll_core import tccs_pkg::*; #(
	parameter int COLUMNS  = DEF_COLUMNS,
	parameter int CELLS    = DEF_CELLS,
	parameter int TAB_STOP = DEF_TAB_STOP
) (
	input  logic         clk,
	input  logic         arst_n,
	tccs_chan_if.sink    req,
	tccs_chan_if.source  rsp
);

	localparam int AW  = $clog2(CELLS);
	localparam int NW  = $clog2(CELLS + COLUMNS + TAB_STOP);
	localparam int CLW = $clog2(COLUMNS);
	localparam int PW  = $clog2(TAB_STOP + 1);
	localparam int CM  = COLUMNS % TAB_STOP;

	tccs_state_t    st_q;

	// cursor plus its column and phase within the tab grid; rs_q is the
	// tab phase of the current row start
	logic [AW-1:0]  cursor_q;
	logic [CLW-1:0] col_q;
	logic [PW-1:0]  ph_q;
	logic [PW-1:0]  rs_q;

	logic           op_s1;
	logic [7:0]     ch_s1;
	logic           ok_s1;

	tccs_out_t      res_q;
	tccs_out_t      out_q;
	logic           out_vld_q;

	logic           accept;
	logic           busy;
	logic           out_free;
	logic           out_load;
	logic           cur_ok;
	logic [15:0]    rd_data;
	logic [AW-1:0]  rd_addr;
	logic           wr_en;
	logic           plain;
	logic           is_put;
	logic           scroll;
	logic [AW+10:0] idx_ext;
	logic [AW+10:0] cur_ext;
	tccs_out_t      res_d;

	logic [AW-1:0]  f_cur;
	logic [CLW-1:0] f_col;
	logic [PW-1:0]  f_ph;
	logic [PW-1:0]  f_rs;

	assign accept    = req.valid && req.ready;
	assign req.ready = (st_q == ST_IDLE) && !busy;
	assign out_free  = !out_vld_q || rsp.ready;
	assign out_load  = out_free && (((st_q == ST_EXEC) && !(is_put && scroll)) ||
	                                (st_q == ST_DONE));
	assign rsp.valid = out_vld_q;
	assign rsp.data  = out_q;

	assign idx_ext = {{AW{1'b0}}, req.data.cell_index};
	assign rd_addr = (req.data.operation == OP_READ) ? idx_ext[AW-1:0] : cursor_q;

	assign is_put = (op_s1 == OP_PUT);
	assign plain  = (ch_s1 != CH_NEWLINE) && (ch_s1 != CH_TAB) && (ch_s1 != CH_BACKSPACE);
	// store writes only in EXEC; the next read is issued no earlier than the
	// following cycle, so no forwarding path is needed
	assign wr_en  = (st_q == ST_EXEC) && is_put && plain;

	assign cur_ok = (32'(cursor_q) < CELLS) && (32'(col_q) < COLUMNS) && (32'(ph_q) < TAB_STOP);

	tccs_screen #(
		.COLUMNS (COLUMNS),
		.CELLS   (CELLS)
	) u_screen (
		.clk          (clk),
		.arst_n       (arst_n),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data),
		.wr_en        (wr_en),
		.wr_addr      (cursor_q),
		.wr_data      ({rd_data[15:8], ch_s1}),
		.scroll_start ((st_q == ST_EXEC) && is_put && scroll),
		.busy         (busy)
	);

	always_comb begin
		logic [NW-1:0]  n_cur;
		logic [CLW-1:0] n_col;
		logic [PW-1:0]  n_ph;
		logic [PW-1:0]  n_rs;
		logic [PW:0]    rs_cm_w;
		logic [PW-1:0]  rs_cm;
		logic [PW-1:0]  ph_inc;
		logic [PW-1:0]  ph_dec;
		logic [CLW:0]   col_tab;
		logic [PW:0]    ph_sub;
		logic [PW:0]    rs_sub;

		rs_cm_w = (PW+1)'(rs_q) + (PW+1)'(CM);
		rs_cm   = (rs_cm_w >= (PW+1)'(TAB_STOP)) ? PW'(rs_cm_w - (PW+1)'(TAB_STOP))
		                                         : PW'(rs_cm_w);
		ph_inc  = (ph_q == PW'(TAB_STOP - 1)) ? '0 : ph_q + PW'(1);
		ph_dec  = (ph_q == '0) ? PW'(TAB_STOP - 1) : ph_q - PW'(1);
		col_tab = (CLW+1)'(col_q) + (CLW+1)'(TAB_STOP) - (CLW+1)'(ph_q);

		n_cur = NW'(cursor_q);
		n_col = col_q;
		n_ph  = ph_q;
		n_rs  = rs_q;
		if (ch_s1 == CH_NEWLINE) begin
			n_cur = NW'(cursor_q) + NW'(COLUMNS) - NW'(col_q);
			n_col = '0;
			n_ph  = rs_cm;
			n_rs  = rs_cm;
		end else if (ch_s1 == CH_TAB) begin
			n_cur = NW'(cursor_q) + NW'(TAB_STOP) - NW'(ph_q);
			n_ph  = '0;
			if (col_tab >= (CLW+1)'(COLUMNS)) begin
				n_col = CLW'(col_tab - (CLW+1)'(COLUMNS));
				n_rs  = rs_cm;
			end else begin
				n_col = CLW'(col_tab);
			end
		end else if (ch_s1 == CH_BACKSPACE) begin
			if (col_q != '0) begin
				n_cur = NW'(cursor_q) - NW'(1);
				n_col = col_q - CLW'(1);
				n_ph  = ph_dec;
			end
		end else begin
			n_cur = NW'(cursor_q) + NW'(1);
			n_ph  = ph_inc;
			if (col_q == CLW'(COLUMNS - 1)) begin
				n_col = '0;
				n_rs  = ph_inc;
			end else begin
				n_col = col_q + CLW'(1);
			end
		end

		scroll = (n_cur >= NW'(CELLS));
		ph_sub = ((PW+1)'(n_ph) >= (PW+1)'(CM)) ? (PW+1)'(n_ph) - (PW+1)'(CM)
		                                         : (PW+1)'(n_ph) + (PW+1)'(TAB_STOP - CM);
		rs_sub = ((PW+1)'(n_rs) >= (PW+1)'(CM)) ? (PW+1)'(n_rs) - (PW+1)'(CM)
		                                         : (PW+1)'(n_rs) + (PW+1)'(TAB_STOP - CM);

		f_cur = AW'(n_cur);
		f_col = n_col;
		f_ph  = n_ph;
		f_rs  = n_rs;
		if (scroll) begin
			if (n_cur >= NW'(COLUMNS)) begin
				f_cur = AW'(n_cur - NW'(COLUMNS));
				f_ph  = PW'(ph_sub);
				f_rs  = PW'(rs_sub);
			end else begin
				// screen smaller than one row: cursor clamps to 0
				f_cur = '0;
				f_col = '0;
				f_ph  = '0;
				f_rs  = '0;
			end
		end
	end

	always_comb begin
		cur_ext              = {11'b0, is_put ? f_cur : cursor_q};
		res_d.cursor_out     = cur_ext[10:0];
		res_d.cell_value     = (!is_put && ok_s1) ? rd_data : 16'h0000;
		res_d.scrolled       = is_put && scroll;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= req.data.operation;
			ch_s1 <= req.data.char_code;
			ok_s1 <= (32'(req.data.cell_index) < CELLS);
		end
		if (st_q == ST_EXEC) begin
			res_q <= res_d;
		end
		if ((st_q == ST_EXEC) && !(is_put && scroll) && out_free) begin
			out_q <= res_d;
		end else if ((st_q == ST_DONE) && out_free) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			cursor_q  <= '0;
			col_q     <= '0;
			ph_q      <= '0;
			rs_q      <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						st_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (is_put) begin
						cursor_q <= f_cur;
						col_q    <= f_col;
						ph_q     <= f_ph;
						rs_q     <= f_rs;
					end
					if (is_put && scroll) begin
						st_q <= ST_SCROLL;
					end else if (out_free) begin
						st_q <= ST_IDLE;
					end else begin
						st_q <= ST_DONE;
					end
				end
				ST_SCROLL: begin
					if (!busy) begin
						st_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ASSERT_ALWAYS(a_no_wr_in_sweep, !(wr_en && busy), "store write collides with sweep")
	`ASSERT_ALWAYS(a_cursor_range, (st_q != ST_IDLE) || cur_ok, "cursor state out of range")
	`ASSERT_NEXT(a_scroll_exit, (st_q == ST_SCROLL) && !busy, st_q == ST_DONE, "scroll stuck")

endmodule
`default_nettype wire

FILE: tb/tb_text_console_cursor_scroll_core.sv
`default_nettype none
module tb_text_console_cursor_scroll_core;
	import tccs_pkg::*;

	localparam int WORD_TARGET = 1950;
	// every word may scroll and wait out the longest gaps on both sides
	localparam int CYCLE_LIMIT = 4 * WORD_TARGET * (DEF_CELLS + 200);

	logic clk;
	logic arst_n;

	tccs_chan_if #(.T(tccs_in_t))  req_if ();
	tccs_chan_if #(.T(tccs_out_t)) rsp_if ();

	text_console_cursor_scroll_core #(
		.COLUMNS  (DEF_COLUMNS),
		.CELLS    (DEF_CELLS),
		.TAB_STOP (DEF_TAB_STOP)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if.sink),
		.rsp    (rsp_if.source)
	);

	// shadow copy of the screen and cursor
	logic [15:0] shadow_screen [DEF_CELLS];
	int unsigned shadow_cursor;

	tccs_in_t  pending_words [$];
	tccs_out_t expected_outs [$];

	int  words_queued;
	int  words_sent;
	int  failures;
	int  cycles;
	int  gap_left;
	int  stall_left;
	logic req_taken;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic tccs_out_t console_next(tccs_in_t w);
		tccs_out_t r;
		int k;
		r = '0;
		if (w.operation == OP_READ) begin
			if (w.cell_index < DEF_CELLS)
				r.cell_value = shadow_screen[w.cell_index];
		end else begin
			case (w.char_code)
			CH_NEWLINE: shadow_cursor = shadow_cursor + DEF_COLUMNS - shadow_cursor % DEF_COLUMNS;
			CH_TAB: shadow_cursor = shadow_cursor + DEF_TAB_STOP - shadow_cursor % DEF_TAB_STOP;
			CH_BACKSPACE: begin
				if (shadow_cursor % DEF_COLUMNS != 0)
					shadow_cursor = shadow_cursor - 1;
			end
			default: begin
				if (shadow_cursor < DEF_CELLS)
					shadow_screen[shadow_cursor][7:0] = w.char_code;
				shadow_cursor = shadow_cursor + 1;
			end
			endcase
			if (shadow_cursor >= DEF_CELLS) begin
				for (k = 0; k < DEF_CELLS; k++)
					shadow_screen[k] = (k + DEF_COLUMNS < DEF_CELLS) ?
						shadow_screen[k + DEF_COLUMNS] : BLANK_CELL;
				shadow_cursor = (shadow_cursor >= DEF_COLUMNS) ?
					shadow_cursor - DEF_COLUMNS : 0;
				r.scrolled = 1'b1;
			end
		end
		r.cursor_out = shadow_cursor[10:0];
		return r;
	endfunction

	task automatic push_put(logic [7:0] ch, logic [10:0] idx);
		tccs_in_t w;
		w.operation  = OP_PUT;
		w.char_code  = ch;
		w.cell_index = idx;
		pending_words.push_back(w);
		words_queued++;
	endtask

	task automatic push_read(logic [10:0] idx, logic [7:0] ch);
		tccs_in_t w;
		w.operation  = OP_READ;
		w.char_code  = ch;
		w.cell_index = idx;
		pending_words.push_back(w);
		words_queued++;
	endtask

	function automatic int spell_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 80)
			return $urandom_range(1, 3);
		else if (p < 95)
			return $urandom_range(4, 15);
		return $urandom_range(20, 80);
	endfunction

	// sender: every third block of 200 words goes back to back
	function automatic int pick_gap();
		if ((words_sent / 200) % 3 == 2 || $urandom_range(0, 1) == 0)
			return 0;
		return spell_len();
	endfunction

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
		end else if (!req_if.valid || req_taken) begin
			if (gap_left > 0) begin
				gap_left = gap_left - 1;
				req_if.valid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				req_if.data  <= pending_words.pop_front();
				req_if.valid <= 1'b1;
				words_sent = words_sent + 1;
				gap_left = pick_gap();
			end else begin
				req_if.valid <= 1'b0;
			end
		end
	end

	// response ready, with quiet stretches where no new stall starts
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left = stall_left - 1;
			rsp_if.ready <= 1'b0;
		end else if (cycles[11:10] != 2'b11 && $urandom_range(0, 3) == 0) begin
			stall_left = spell_len() - 1;
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= 1'b1;
		end
	end

	// accepted requests feed the predictor
	always @(posedge clk) begin
		req_taken <= req_if.valid && req_if.ready;
		if (arst_n && req_if.valid && req_if.ready)
			expected_outs.push_back(console_next(req_if.data));
	end

	// response checker
	always @(posedge clk) begin
		tccs_out_t want;
		tccs_out_t got;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got = rsp_if.data;
			if (expected_outs.size() == 0) begin
				$error("unexpected word: cursor_out %0d cell_value %h scrolled %0d",
					got.cursor_out, got.cell_value, got.scrolled);
				failures++;
			end else begin
				want = expected_outs.pop_front();
				if (got.cursor_out !== want.cursor_out) begin
					$error("cursor_out: expected %0d, got %0d", want.cursor_out, got.cursor_out);
					failures++;
				end
				if (got.cell_value !== want.cell_value) begin
					$error("cell_value: expected %h, got %h", want.cell_value, got.cell_value);
					failures++;
				end
				if (got.scrolled !== want.scrolled) begin
					$error("scrolled: expected %0d, got %0d", want.scrolled, got.scrolled);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		int p;
		int s;
		int k;
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.data = '0;
		rsp_if.ready = 1'b0;
		req_taken = 1'b0;
		words_queued = 0;
		words_sent = 0;
		failures = 0;
		cycles = 0;
		gap_left = 0;
		stall_left = 0;
		shadow_cursor = 0;
		for (k = 0; k < DEF_CELLS; k++)
			shadow_screen[k] = BLANK_CELL;

		// directed: store edges, out-of-range reads, each control byte
		push_read(11'd0, 8'd0);
		push_read(11'd1999, 8'hFF);
		push_read(11'd2000, 8'd0);
		push_read(11'd2047, CH_NEWLINE);
		push_put(8'h41, 11'd2047);
		push_put(8'h00, 11'd0);
		push_put(8'hFF, 11'd1234);
		push_put(CH_BACKSPACE, 11'd0);
		push_read(11'd0, 8'd0);
		push_read(11'd2, CH_TAB);
		push_put(CH_TAB, 11'd0);
		push_put(CH_TAB, 11'd0);
		push_put(CH_NEWLINE, 11'd0);
		push_put(CH_BACKSPACE, 11'd0);
		push_put(CH_TAB, 11'd0);
		push_put(8'h7F, 11'd0);
		push_put(CH_BACKSPACE, 11'd0);
		push_put(8'h80, 11'h555);
		push_read(11'd80, 8'd0);
		push_read(11'h2AA, 8'h55);
		push_read(11'd1, 8'hAA);

		while (words_queued < WORD_TARGET) begin
			p = $urandom_range(0, 99);
			if (p < 3) begin
				// enough newlines to force a scroll, then keep typing
				repeat (30) push_put(CH_NEWLINE, 11'($urandom_range(0, 2047)));
			end else if (p < 5) begin
				repeat ($urandom_range(60, 100))
					push_put(8'($urandom_range(32, 126)), 11'($urandom_range(0, 2047)));
			end else if (p < 30) begin
				push_read(11'($urandom_range(0, 2047)), 8'($urandom_range(0, 255)));
			end else begin
				s = $urandom_range(0, 99);
				if (s < 18)
					push_put(CH_NEWLINE, 11'($urandom_range(0, 2047)));
				else if (s < 26)
					push_put(CH_TAB, 11'($urandom_range(0, 2047)));
				else if (s < 34)
					push_put(CH_BACKSPACE, 11'($urandom_range(0, 2047)));
				else
					push_put(8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
			end
		end

		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		while (pending_words.size() > 0 || req_if.valid)
			@(posedge clk);
		while (expected_outs.size() > 0)
			@(posedge clk);
		repeat (DEF_CELLS + 16) @(posedge clk);

		if (failures == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
`default_nettype wire
